// ----- hdl/awn_pkg.sv -----
`timescale 1ns / 1ps
package awn_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int COEF_W  = 16;
  localparam int CRD_W   = 10;
  localparam int SIZE_W  = 9;
  localparam int SHIFT_W = 11;
  localparam int PROD_W  = 2 * COEF_W;
  localparam int DET_W   = PROD_W + 1;
  localparam int DMAG_W  = PROD_W;
  localparam int SHDET_W = SHIFT_W + DET_W;
  localparam int NUM_W   = SHDET_W + 2;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int CFG_W   = 16;
  localparam int FRAC_W  = 12;

  // map stages: products, difference, numerator
  localparam int MAP_LAT = 3;

  localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH  = 9'd256;
  localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT = 9'd256;
  localparam logic [COEF_W-1:0]  RST_COEF_A       = 16'sd4096;
  localparam logic [COEF_W-1:0]  RST_COEF_B       = 16'sd0;
  localparam logic [COEF_W-1:0]  RST_COEF_C       = 16'sd0;
  localparam logic [COEF_W-1:0]  RST_COEF_D       = 16'sd4096;
  localparam logic [SHIFT_W-1:0] RST_SHIFT_X      = 11'sd30;
  localparam logic [SHIFT_W-1:0] RST_SHIFT_Y      = -11'sd30;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_A       = 3'd2,
    REG_COEF_B       = 3'd3,
    REG_COEF_C       = 3'd4,
    REG_COEF_D       = 3'd5,
    REG_SHIFT_X      = 3'd6,
    REG_SHIFT_Y      = 3'd7
  } reg_idx_t;

  // determinant as sign and magnitude, for the divider
  typedef struct packed {
    logic              neg;
    logic [DMAG_W-1:0] mag;
  } det_t;

endpackage

// ----- hdl/awn_map.sv -----
`timescale 1ns / 1ps
// numerator p*u - q*v, scaled by 4096, minus shift*det
module awn_map (
  input  logic                               clk,
  input  logic                               en,
  input  logic [awn_pkg::CRD_W-1:0]          u,
  input  logic [awn_pkg::CRD_W-1:0]          v,
  input  logic signed [awn_pkg::COEF_W-1:0]  p,
  input  logic signed [awn_pkg::COEF_W-1:0]  q,
  input  logic signed [awn_pkg::SHDET_W-1:0] shdet,
  output logic signed [awn_pkg::NUM_W-1:0]   num
);
  import awn_pkg::*;

  localparam int PU_W = COEF_W + CRD_W + 1;

  logic signed [PU_W-1:0] pu;
  logic signed [PU_W-1:0] qv;
  logic signed [PU_W:0]   n;

  always_ff @(posedge clk) begin
    if (en) begin
      pu  <= p * $signed({1'b0, u});
      qv  <= q * $signed({1'b0, v});
      n   <= (PU_W+1)'(pu) - (PU_W+1)'(qv);
      num <= (NUM_W'(n) <<< FRAC_W) - NUM_W'(shdet);
    end
  end

endmodule

// ----- hdl/awn_div.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit per stage; quotient limited to QW bits
module awn_div #(
  parameter int QW = 8
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [awn_pkg::NUM_W-1:0] num,
  input  awn_pkg::det_t                    dv,
  output logic [QW-1:0]                    quo,
  output logic                             ovf,
  output logic                             neg
);
  import awn_pkg::*;

  logic [NUM_W-1:0] mag;
  logic             neg_a;
  logic [NUM_W-1:0] rem  [QW];
  logic [QW-1:0]    qq   [QW];
  logic             ov   [QW];
  logic             ng   [QW];
  logic             ge   [QW];
  logic [NUM_W-1:0] diff [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      ge[k]   = rem[k] >= (NUM_W'(dv.mag) << (QW - 1 - k));
      diff[k] = rem[k] - (NUM_W'(dv.mag) << (QW - 1 - k));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      neg_a  <= num[NUM_W-1] ^ dv.neg;
      // zero det also lands here: everything is >= 0
      ov[0]  <= mag >= (NUM_W'(dv.mag) << QW);
      ng[0]  <= neg_a;
      rem[0] <= mag;
      qq[0]  <= '0;
      for (int k = 0; k < QW - 1; k++) begin
        rem[k+1] <= ge[k] ? diff[k] : rem[k];
        qq[k+1]  <= qq[k] | (QW'(ge[k]) << (QW - 1 - k));
        ov[k+1]  <= ov[k];
        ng[k+1]  <= ng[k];
      end
      quo <= qq[QW-1] | QW'(ge[QW-1]);
      ovf <= ov[QW-1];
      neg <= ng[QW-1];
    end
  end

endmodule

// ----- hdl/awn_frame.sv -----
`timescale 1ns / 1ps
// frame store, one write or one read per advance, registered read data
module awn_frame #(
  parameter int AW = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      we,
  input  logic                      re,
  input  logic [AW-1:0]             addr,
  input  logic [awn_pkg::PIX_W-1:0] wdata,
  output logic [awn_pkg::PIX_W-1:0] rdata
);
  import awn_pkg::*;

  logic [PIX_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en && re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hdl/affine_warp_nearest_core.sv -----
`timescale 1ns / 1ps
// Pipeline: an accepted query word passes the input register, the map, the
//   divider, the final compare and the frame read to the output; QW is the
//   quotient width, clog2 of the larger frame maximum.
// Throughput: one word per cycle while the output moves; the divider pipelines are one bit per stage.
// Reset: sync active-high rst clears valid bits and restores the registers;
//   the frame store is not cleared and is undefined until loaded.
module affine_warp_nearest_core #(
  parameter int MAX_WIDTH  = awn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = awn_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst,
  // config write port
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_addr,
  input  logic [awn_pkg::CFG_W-1:0]  cfg_data,
  // input words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [awn_pkg::CRD_W-1:0]  col,
  input  logic [awn_pkg::CRD_W-1:0]  row,
  input  logic [awn_pkg::CH_W-1:0]   blue_in,
  input  logic [awn_pkg::CH_W-1:0]   green_in,
  input  logic [awn_pkg::CH_W-1:0]   red_in,
  // result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [awn_pkg::CH_W-1:0]   blue_out,
  output logic [awn_pkg::CH_W-1:0]   green_out,
  output logic [awn_pkg::CH_W-1:0]   red_out,
  output logic                       inside_res
);
  import awn_pkg::*;

  localparam int QW_X    = $clog2(MAX_WIDTH);
  localparam int QW_Y    = $clog2(MAX_HEIGHT);
  localparam int QW      = (QW_X > QW_Y) ? QW_X : QW_Y;
  localparam int AW      = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DIV_LAT = QW + 2;
  localparam int PIPE    = MAP_LAT + DIV_LAT;
  localparam int LIM_W   = CRD_W + 1;

  // ---------------- config registers ----------------
  logic [SIZE_W-1:0]         frame_width, frame_height;
  logic signed [COEF_W-1:0]  coef_a, coef_b, coef_c, coef_d;
  logic signed [SHIFT_W-1:0] shift_x, shift_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      coef_a       <= RST_COEF_A;
      coef_b       <= RST_COEF_B;
      coef_c       <= RST_COEF_C;
      coef_d       <= RST_COEF_D;
      shift_x      <= RST_SHIFT_X;
      shift_y      <= RST_SHIFT_Y;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[SIZE_W-1:0];
        REG_COEF_A:       coef_a       <= cfg_data[COEF_W-1:0];
        REG_COEF_B:       coef_b       <= cfg_data[COEF_W-1:0];
        REG_COEF_C:       coef_c       <= cfg_data[COEF_W-1:0];
        REG_COEF_D:       coef_d       <= cfg_data[COEF_W-1:0];
        REG_SHIFT_X:      shift_x      <= cfg_data[SHIFT_W-1:0];
        REG_SHIFT_Y:      shift_y      <= cfg_data[SHIFT_W-1:0];
        default:          ;
      endcase
    end
  end

  // Derived constants are registered from prod_ad/prod_bc to det to shdet and dv; the user
  // must change config only while idle (not enforced here) so the pipeline never sees a stale value.
  logic signed [PROD_W-1:0]  prod_ad, prod_bc;
  logic signed [DET_W-1:0]   det;
  logic signed [SHDET_W-1:0] shdet_x, shdet_y;
  det_t                      dv;

  always_ff @(posedge clk) begin
    prod_ad <= coef_a * coef_d;
    prod_bc <= coef_b * coef_c;
    det     <= DET_W'(prod_ad) - DET_W'(prod_bc);
    shdet_x <= shift_x * det;
    shdet_y <= shift_y * det;
    dv.neg  <= det[DET_W-1];
    dv.mag  <= det[DET_W-1] ? DMAG_W'(-det) : DMAG_W'(det);
  end

  // clamped frame limits
  logic [LIM_W-1:0] lim_w, lim_h;
  assign lim_w = (LIM_W'(frame_width) > LIM_W'(MAX_WIDTH)) ? LIM_W'(MAX_WIDTH)
                                                            : LIM_W'(frame_width);
  assign lim_h = (LIM_W'(frame_height) > LIM_W'(MAX_HEIGHT)) ? LIM_W'(MAX_HEIGHT)
                                                              : LIM_W'(frame_height);

  // ---------------- pipeline control ----------------
  // whole pipe moves together; it holds only when a result word is stuck
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // input register
  logic              s0_valid, s0_type, s0_wr;
  logic [CRD_W-1:0]  s0_col, s0_row;
  logic [PIX_W-1:0]  s0_pix;
  logic [AW-1:0]     s0_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_type <= req_type;
      s0_col  <= col;
      s0_row  <= row;
      s0_pix  <= {red_in, green_in, blue_in};
      // loads outside the store are dropped
      s0_wr   <= (LIM_W'(col) < LIM_W'(MAX_WIDTH)) && (LIM_W'(row) < LIM_W'(MAX_HEIGHT));
      s0_addr <= AW'(32'(row) * MAX_WIDTH + 32'(col));
    end
  end

  // ---------------- coordinate map and divide ----------------
  logic signed [NUM_W-1:0] num_x, num_y;
  logic [QW-1:0]           q_x, q_y;
  logic                    ovf_x, ovf_y, neg_x, neg_y;

  awn_map u_map_x (
    .clk(clk), .en(adv), .u(s0_col), .v(s0_row),
    .p(coef_d), .q(coef_b), .shdet(shdet_x), .num(num_x)
  );

  awn_map u_map_y (
    .clk(clk), .en(adv), .u(s0_row), .v(s0_col),
    .p(coef_a), .q(coef_c), .shdet(shdet_y), .num(num_y)
  );

  awn_div #(.QW(QW)) u_div_x (
    .clk(clk), .en(adv), .num(num_x), .dv(dv),
    .quo(q_x), .ovf(ovf_x), .neg(neg_x)
  );

  awn_div #(.QW(QW)) u_div_y (
    .clk(clk), .en(adv), .num(num_y), .dv(dv),
    .quo(q_y), .ovf(ovf_y), .neg(neg_y)
  );

  // side line keeps each word's control and load data aligned with the divider
  logic             sd_valid [PIPE];
  logic             sd_type  [PIPE];
  logic             sd_wr    [PIPE];
  logic [AW-1:0]    sd_addr  [PIPE];
  logic [PIX_W-1:0] sd_pix   [PIPE];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE; i++) sd_valid[i] <= 1'b0;
    end else if (adv) begin
      sd_valid[0] <= s0_valid;
      for (int i = 1; i < PIPE; i++) sd_valid[i] <= sd_valid[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_type[0] <= s0_type;
      sd_wr[0]   <= s0_wr;
      sd_addr[0] <= s0_addr;
      sd_pix[0]  <= s0_pix;
      for (int i = 1; i < PIPE; i++) begin
        sd_type[i] <= sd_type[i-1];
        sd_wr[i]   <= sd_wr[i-1];
        sd_addr[i] <= sd_addr[i-1];
        sd_pix[i]  <= sd_pix[i-1];
      end
    end
  end

  // ---------------- range check ----------------
  // truncation toward zero: a negative quotient of zero magnitude is column or row 0
  logic          in_x, in_y, hit;
  logic [AW-1:0] rd_addr;

  assign in_x    = !ovf_x && (!neg_x || (q_x == '0)) && (LIM_W'(q_x) < lim_w);
  assign in_y    = !ovf_y && (!neg_y || (q_y == '0)) && (LIM_W'(q_y) < lim_h);
  assign hit     = in_x && in_y;
  assign rd_addr = AW'(32'(q_y) * MAX_WIDTH + 32'(q_x));

  logic             fin_valid, fin_type, fin_we, fin_re, fin_inside;
  logic [AW-1:0]    fin_addr;
  logic [PIX_W-1:0] fin_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= sd_valid[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_type   <= sd_type[PIPE-1];
      fin_we     <= sd_valid[PIPE-1] && (sd_type[PIPE-1] == REQ_LOAD) && sd_wr[PIPE-1];
      fin_re     <= sd_valid[PIPE-1] && (sd_type[PIPE-1] == REQ_QUERY) && hit;
      fin_inside <= hit;
      fin_addr   <= (sd_type[PIPE-1] == REQ_LOAD) ? sd_addr[PIPE-1] : rd_addr;
      fin_pix    <= sd_pix[PIPE-1];
    end
  end

  // ---------------- frame store and output ----------------
  // loads and queries touch the store in the same stage, so order is kept
  logic [PIX_W-1:0] rdata;

  awn_frame #(.AW(AW)) u_frame (
    .clk(clk), .en(adv), .we(fin_we), .re(fin_re),
    .addr(fin_addr), .wdata(fin_pix), .rdata(rdata)
  );

  logic out_inside;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fin_valid && (fin_type == REQ_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_inside <= fin_inside;
    end
  end

  assign inside_res = out_inside;
  assign blue_out   = out_inside ? rdata[CH_W-1:0]        : '0;
  assign green_out  = out_inside ? rdata[2*CH_W-1:CH_W]   : '0;
  assign red_out    = out_inside ? rdata[3*CH_W-1:2*CH_W] : '0;

endmodule

// ----- hdl/awn_checker.sv -----
`timescale 1ns / 1ps
module awn_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [awn_pkg::CH_W-1:0]  blue_out,
  input logic [awn_pkg::CH_W-1:0]  green_out,
  input logic [awn_pkg::CH_W-1:0]  red_out,
  input logic                      inside_res
);
  import awn_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({blue_out, green_out, red_out, inside_res}))
    else $error("stalled result word changed");

  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipe is stalled");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_res |-> (blue_out == '0) && (green_out == '0) && (red_out == '0))
    else $error("outside pixel not zero");

endmodule

bind affine_warp_nearest_core awn_checker u_awn_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .blue_out(blue_out), .green_out(green_out),
  .red_out(red_out), .inside_res(inside_res)
);

// ----- bench/tb_affine_warp_nearest_core.sv -----
`timescale 1ns / 1ps
module tb_affine_warp_nearest_core;
  import awn_pkg::*;

  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int STORE_W      = DEF_MAX_WIDTH;
  localparam int STORE_H      = DEF_MAX_HEIGHT;

  typedef struct {
    bit [7:0] blue;
    bit [7:0] green;
    bit [7:0] red;
    bit       in_frame;
  } warp_pixel_t;

  // Keeps its own copy of the registers and the frame store, maps each
  // accepted query back to its source pixel and queues the expected word.
  class warp_scoreboard;
    bit [23:0]          frame[STORE_W*STORE_H];
    bit                 loaded[STORE_W*STORE_H];
    logic [8:0]         width, height;
    logic signed [15:0] ca, cb, cc, cd;
    logic signed [10:0] sx, sy;
    warp_pixel_t        pending_px[$];
    int                 errors, checked, loads, hits;

    function void reset_regs();
      width  = RST_FRAME_WIDTH;
      height = RST_FRAME_HEIGHT;
      ca = RST_COEF_A;
      cb = RST_COEF_B;
      cc = RST_COEF_C;
      cd = RST_COEF_D;
      sx = RST_SHIFT_X;
      sy = RST_SHIFT_Y;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_FRAME_WIDTH:  width  = v[8:0];
        REG_FRAME_HEIGHT: height = v[8:0];
        REG_COEF_A:       ca = v;
        REG_COEF_B:       cb = v;
        REG_COEF_C:       cc = v;
        REG_COEF_D:       cd = v;
        REG_SHIFT_X:      sx = v[10:0];
        REG_SHIFT_Y:      sy = v[10:0];
        default: ;
      endcase
    endfunction

    // inverse map of output (x,y); hit when the source lies in the frame
    function void map_src(int x, int y, output longint sc, output longint sr,
                          output bit hit);
      longint a, b, c, d, dx, dy, det, w, h;
      a = ca; b = cb; c = cc; d = cd; dx = sx; dy = sy;
      w = (width > STORE_W) ? STORE_W : width;
      h = (height > STORE_H) ? STORE_H : height;
      det = a * d - b * c;
      sc = 0; sr = 0; hit = 0;
      if (det != 0) begin
        sc = ((d * x - b * y) * 4096 - dx * det) / det;
        sr = ((a * y - c * x) * 4096 - dy * det) / det;
        hit = (sc >= 0) && (sc < w) && (sr >= 0) && (sr < h);
      end
    endfunction

    function void note_word(bit typ, int x, int y, bit [7:0] b, bit [7:0] g,
                            bit [7:0] r);
      longint sc, sr;
      bit hit;
      warp_pixel_t px;
      if (typ == REQ_LOAD) begin
        if (x < STORE_W && y < STORE_H) begin
          frame[y*STORE_W + x]  = {r, g, b};
          loaded[y*STORE_W + x] = 1;
          loads++;
        end
      end else begin
        map_src(x, y, sc, sr, hit);
        px = '{8'd0, 8'd0, 8'd0, 1'b0};
        if (hit) begin
          {px.red, px.green, px.blue} = frame[sr*STORE_W + sc];
          px.in_frame = 1;
          hits++;
        end
        pending_px.push_back(px);
      end
    endfunction

    function void check_word(bit [7:0] b, bit [7:0] g, bit [7:0] r, bit ins);
      warp_pixel_t e;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected word b=%0d g=%0d r=%0d inside=%0d",
                 $time, b, g, r, ins);
        errors++;
        return;
      end
      e = pending_px.pop_front();
      checked++;
      if (e.blue != b || e.green != g || e.red != r || e.in_frame != ins) begin
        $display("%0t: mismatch expected b=%0d g=%0d r=%0d inside=%0d,",
                 $time, e.blue, e.green, e.red, e.in_frame,
                 " got b=%0d g=%0d r=%0d inside=%0d", b, g, r, ins);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_addr;
  logic [15:0] cfg_data;
  logic       in_valid, in_ready;
  logic       req_type;
  logic [9:0] col, row;
  logic [7:0] blue_in, green_in, red_in;
  logic       out_valid, out_ready;
  logic [7:0] blue_out, green_out, red_out;
  logic       inside_res;

  warp_scoreboard sb = new();
  bit quiet;        // no idling on either side while set
  int cycles;
  int phases;

  affine_warp_nearest_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .col(col), .row(row),
    .blue_in(blue_in), .green_in(green_in), .red_in(red_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .blue_out(blue_out), .green_out(green_out), .red_out(red_out),
    .inside_res(inside_res)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: check accepted words, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word(blue_out, green_out, red_out, inside_res);
    out_ready <= quiet || ($urandom_range(99) >= 22);
  end

  // one input word; called just after a rising edge
  task automatic put_word(bit typ, int x, int y, bit [7:0] b, bit [7:0] g,
                          bit [7:0] r);
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    req_type <= typ;
    col      <= x[9:0];
    row      <= y[9:0];
    blue_in  <= b;
    green_in <= g;
    red_in   <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_word(typ, int'(x[9:0]), int'(y[9:0]), b, g, r);
  endtask

  task automatic load_px(int x, int y);
    put_word(REQ_LOAD, x, y, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // query; a source pixel never loaded is loaded first
  task automatic query_px(int x, int y);
    longint sc, sr;
    bit hit;
    sb.map_src(int'(x[9:0]), int'(y[9:0]), sc, sr, hit);
    if (hit && !sb.loaded[sr*STORE_W + sc])
      load_px(int'(sc), int'(sr));
    put_word(REQ_QUERY, x, y, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // block must be drained before a register changes
  task automatic drain();
    in_valid <= 0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(int w, int h, int a, int b, int c, int d, int dx,
                          int dy);
    int vals[8];
    reg_idx_t idx;
    vals = '{w, h, a, b, c, d, dx, dy};
    drain();
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      cfg_we   <= 1;
      cfg_addr <= idx;
      cfg_data <= vals[i][15:0];
      @(posedge clk);
      sb.write_reg(idx, vals[i][15:0]);
    end
    cfg_we <= 0;
    phases++;
  endtask

  // random traffic for the current setting
  task automatic random_words(int n, int span);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 60)
        query_px($urandom_range(span), $urandom_range(span));
      else if (k < 85)
        load_px($urandom_range(STORE_W-1), $urandom_range(STORE_H-1));
      else if (k < 93)
        query_px($urandom_range(1023), $urandom_range(1023));
      else
        load_px($urandom_range(1023), $urandom_range(1023));
    end
  endtask

  function automatic int rand_coef();
    int m;
    m = $urandom_range(8192, 2048);
    return $urandom_range(1) ? m : -m;
  endfunction

  initial begin
    rst <= 1;
    cfg_we <= 0; cfg_addr <= REG_FRAME_WIDTH; cfg_data <= 0;
    in_valid <= 0; req_type <= REQ_LOAD; col <= 0; row <= 0;
    blue_in <= 0; green_in <= 0; red_in <= 0;
    out_ready <= 0;
    cycles <= 0;
    quiet = 0;
    sb.reset_regs();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed, reset setting: corners, out-of-store loads, extreme coords
    put_word(REQ_LOAD, 0, 0, 8'hff, 8'h00, 8'hff);
    put_word(REQ_LOAD, 255, 255, 8'h00, 8'hff, 8'h00);
    put_word(REQ_LOAD, 256, 0, 8'h55, 8'haa, 8'h55);
    put_word(REQ_LOAD, 0, 256, 8'haa, 8'h55, 8'haa);
    put_word(REQ_LOAD, 1023, 1023, 8'hff, 8'hff, 8'hff);
    query_px(30, 0);
    query_px(29, 0);
    query_px(285, 225);
    query_px(286, 225);
    query_px(0, 0);
    query_px(1023, 1023);
    query_px(0, 1023);

    // pause the sender until the pipeline is empty
    in_valid <= 0;
    while (sb.pending_px.size() != 0) @(posedge clk);

    // identity, then zero determinant, then extremes of every register
    set_regs(256, 256, 4096, 0, 0, 4096, 0, 0);
    query_px(0, 0); query_px(255, 255); query_px(256, 255);
    set_regs(256, 256, 4096, 8192, 2048, 4096, 0, 0);
    query_px(10, 10); query_px(0, 0);
    set_regs(1, 1, 4096, 0, 0, 4096, 0, 0);
    query_px(0, 0); query_px(1, 0); query_px(0, 1);
    set_regs(0, 511, 4096, 0, 0, 4096, 0, 0);
    query_px(0, 0);
    set_regs(511, 0, 4096, 0, 0, 4096, 0, 0);
    query_px(0, 0);
    set_regs(511, 511, -32768, 32767, 32767, -32768, -1024, 1023);
    random_words(30, 1023);
    set_regs(511, 511, 32767, -32768, -32768, 32767, 1023, -1024);
    random_words(30, 1023);

    // hand-picked geometry: scale, rotation
    set_regs(100, 60, 8192, 0, 0, 8192, 5, -7);
    random_words(100, 260);
    set_regs(256, 256, 3547, -2048, 2048, 3547, -100, 50);
    quiet = 1;
    random_words(150, 300);
    quiet = 0;

    // random settings, mostly well-behaved, a few fully random
    for (int p = 0; p < 9; p++) begin
      if (p % 3 == 2)
        set_regs($urandom_range(511), $urandom_range(511), $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
      else
        set_regs($urandom_range(300, 1), $urandom_range(300, 1), rand_coef(),
                 $urandom_range(1) ? rand_coef() / 4 : 0,
                 $urandom_range(1) ? rand_coef() / 4 : 0, rand_coef(),
                 $urandom_range(120) - 60, $urandom_range(120) - 60);
      random_words(100, 400);
    end

    drain();
    $display("Checked %0d result words over %0d register settings;", sb.checked,
             phases, " %0d loads, %0d in-frame hits.", sb.loads, sb.hits);
    if (sb.errors == 0 && sb.pending_px.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/awn_pkg.sv
hdl/awn_map.sv
hdl/awn_div.sv
hdl/awn_frame.sv
hdl/affine_warp_nearest_core.sv
hdl/awn_checker.sv
bench/tb_affine_warp_nearest_core.sv
